// ----- rtl/xo256_pkg.sv -----
`default_nettype none
package xo256_pkg;

    localparam int WordW = 64;

    typedef enum logic [2:0] {
        MODE_DRAW     = 3'd0,
        MODE_BOUNDED  = 3'd1,
        MODE_RESEED   = 3'd2,
        MODE_JUMP     = 3'd3,
        MODE_LONGJUMP = 3'd4
    } mode_t;

    localparam logic [63:0] GoldenGamma = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MixMulA     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MixMulB     = 64'h94d049bb133111eb;

    localparam logic [255:0] JumpShort = {64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
                                          64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
    localparam logic [255:0] JumpLong  = {64'h39109bb02acbe635, 64'h77710069854ee241,
                                          64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

    // state after seeding with zero
    localparam logic [63:0] Seed0S0 = 64'he220a8397b1dcdaf;
    localparam logic [63:0] Seed0S1 = 64'h6e789e6aa1b965f4;
    localparam logic [63:0] Seed0S2 = 64'h06c45d188009454f;
    localparam logic [63:0] Seed0S3 = 64'hf88bb8a8724c81ec;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_ADVANCE   = 4'd1,  // state step, capture scrambled value
        OP_JACC_CLR  = 4'd2,  // also zeroes the result
        OP_JUMP_STEP = 4'd3,  // conditional accumulate then step
        OP_JUMP_LOAD = 4'd4,
        OP_MIX_ADD   = 4'd5,  // acc += gamma (seed + gamma in slot 0), z = acc
        OP_MIX_PRE   = 4'd6,  // z ^= z >> 30 or 27
        OP_MUL_LL    = 4'd7,  // prod = zl * kl
        OP_MUL_LH    = 4'd8,  // prod += (zl * kh) << 32
        OP_MUL_HL    = 4'd9,  // z = prod + (zh * kl) << 32
        OP_MIX_STORE = 4'd10, // store finished word into state slot
        OP_DIV_INIT  = 4'd11, // begin remainder of dividend by bound
        OP_DIV_STEP  = 4'd12,
        OP_RES_CLR   = 4'd13,
        OP_RES_REM   = 4'd14, // result <= remainder
        OP_THR_SAVE  = 4'd15  // threshold <= remainder
    } op_t;

    typedef enum logic [1:0] {
        DSRC_NEG   = 2'd0, // 0 - bound
        DSRC_VALUE = 2'd1  // last scrambled value
    } dsrc_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  slot;
        logic [7:0]  bit_idx;
        logic        jump_far;
        logic        mix_rnd;  // 0: first splitmix round, 1: second
        logic        capture;  // latch seed and bound of the accepted beat
        dsrc_t       dsrc;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic bound_zero;
        logic accept_val; // value >= threshold
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/xo256_datapath.sv -----
`default_nettype none
module xo256_datapath
    import xo256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [63:0] seed_word,
    input  wire logic [63:0] bound_word,
    output dp_stat_t         stat,
    output logic [63:0]      result
);

    logic [63:0] s_reg [4];
    logic [63:0] jacc_reg [4];
    logic [63:0] mix_acc_reg, z_reg, prod_reg;
    logic [63:0] seed_reg, bound_reg;
    logic [63:0] value_reg, thr_reg, res_reg;
    logic [63:0] rem_reg, dvd_reg;
    logic [6:0]  dcnt_reg;
    logic [63:0] t17, n0, n1, n2, n3, x3;
    logic [63:0] scr1, scr;
    logic [255:0] tab;
    logic [64:0] trial;
    logic [63:0] rem_sh;
    logic [63:0] kmul;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    assign t17 = s_reg[1] << 17;
    assign n2  = s_reg[2] ^ s_reg[0] ^ t17;
    assign x3  = s_reg[3] ^ s_reg[1];
    assign n1  = s_reg[1] ^ s_reg[2] ^ s_reg[0];
    assign n0  = s_reg[0] ^ x3;
    assign n3  = {x3[18:0], x3[63:19]};

    // s1*5 = s1 + s1<<2 ; *9 = v + v<<3
    assign scr1 = s_reg[1] + (s_reg[1] << 2);
    assign scr  = {scr1[56:0], scr1[63:57]} + ({scr1[56:0], scr1[63:57]} << 3);

    assign tab = cmd.jump_far ? JumpLong : JumpShort;

    // one shared 32x32 multiplier; low 64 bits of z * k over three steps
    assign kmul  = cmd.mix_rnd ? MixMulB : MixMulA;
    assign mul_a = (cmd.op == OP_MUL_HL) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b = (cmd.op == OP_MUL_LH) ? kmul[63:32] : kmul[31:0];
    assign mul_p = mul_a * mul_b;

    assign rem_sh = {rem_reg[62:0], dvd_reg[63]};
    assign trial  = {rem_reg[63], rem_sh} - {1'b0, bound_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg[0] <= Seed0S0;
            s_reg[1] <= Seed0S1;
            s_reg[2] <= Seed0S2;
            s_reg[3] <= Seed0S3;
            dcnt_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_ADVANCE, OP_JUMP_STEP:
                begin
                    s_reg[0] <= n0;
                    s_reg[1] <= n1;
                    s_reg[2] <= n2;
                    s_reg[3] <= n3;
                end
                OP_JUMP_LOAD:
                begin
                    for (int i = 0; i < 4; i++) s_reg[i] <= jacc_reg[i];
                end
                OP_MIX_STORE: s_reg[cmd.slot] <= z_reg ^ (z_reg >> 31);
                OP_DIV_INIT:  dcnt_reg <= 7'd64;
                OP_DIV_STEP:  dcnt_reg <= dcnt_reg - 7'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            seed_reg  <= seed_word;
            bound_reg <= bound_word;
        end
        case (cmd.op)
            OP_ADVANCE:
            begin
                value_reg <= scr;
                res_reg   <= scr;
            end
            OP_JACC_CLR:
            begin
                for (int i = 0; i < 4; i++) jacc_reg[i] <= '0;
                res_reg <= '0;
            end
            OP_JUMP_STEP:
            begin
                if (tab[cmd.bit_idx])
                    for (int i = 0; i < 4; i++) jacc_reg[i] <= jacc_reg[i] ^ s_reg[i];
            end
            OP_MIX_ADD:
            begin
                if (cmd.slot == 2'd0)
                begin
                    mix_acc_reg <= seed_reg + GoldenGamma;
                    z_reg       <= seed_reg + GoldenGamma;
                end
                else
                begin
                    mix_acc_reg <= mix_acc_reg + GoldenGamma;
                    z_reg       <= mix_acc_reg + GoldenGamma;
                end
            end
            OP_MIX_PRE:
                z_reg <= cmd.mix_rnd ? (z_reg ^ (z_reg >> 27)) : (z_reg ^ (z_reg >> 30));
            OP_MUL_LL: prod_reg <= mul_p;
            OP_MUL_LH: prod_reg <= prod_reg + {mul_p[31:0], 32'd0};
            OP_MUL_HL: z_reg    <= prod_reg + {mul_p[31:0], 32'd0};
            OP_DIV_INIT:
            begin
                rem_reg <= '0;
                dvd_reg <= (cmd.dsrc == DSRC_NEG) ? (64'd0 - bound_word) : value_reg;
            end
            OP_DIV_STEP:
            begin
                dvd_reg <= dvd_reg << 1;
                rem_reg <= trial[64] ? rem_sh : trial[63:0];
            end
            OP_RES_CLR:  res_reg <= '0;
            OP_RES_REM:  res_reg <= rem_reg;
            OP_THR_SAVE: thr_reg <= rem_reg;
            default: ;
        endcase
    end

    assign stat.div_done   = (dcnt_reg == 7'd0);
    assign stat.bound_zero = (bound_word == 64'd0);
    assign stat.accept_val = (value_reg >= thr_reg);
    assign result = res_reg;

endmodule
`default_nettype wire

// ----- rtl/xo256_ctrl.sv -----
`default_nettype none
module xo256_ctrl
    import xo256_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] mode,
    input  wire logic       out_busy,
    output logic            out_load,
    output dp_cmd_t         cmd,
    input  wire dp_stat_t   stat
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MIXA   = 10'b0000000010,
        S_MIXM   = 10'b0000000100,
        S_JLOAD  = 10'b0000001000,
        S_MIXS   = 10'b0000010000,
        S_JUMP   = 10'b0000100000,
        S_DIV    = 10'b0001000000,
        S_DRAW   = 10'b0010000000,
        S_CHECK  = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [1:0]  slot_reg, slot_next;
    logic        long_reg, long_next;
    logic        phase_reg, phase_next; // 0: threshold div, 1: result div

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            slot_reg  <= '0;
            long_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            slot_reg  <= slot_next;
            long_reg  <= long_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        long_next  = long_reg;
        phase_next = phase_reg;
        out_load   = 1'b0;
        cmd        = '{op: OP_NONE, slot: slot_reg, bit_idx: cnt_reg,
                       jump_far: long_reg, mix_rnd: 1'b0, capture: 1'b0,
                       dsrc: DSRC_NEG};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    case (mode)
                        MODE_DRAW:
                        begin
                            cmd.op = OP_ADVANCE;
                            state_next = S_DONE;
                            phase_next = 1'b0;
                        end
                        MODE_BOUNDED:
                        begin
                            if (stat.bound_zero)
                            begin
                                cmd.op = OP_RES_CLR;
                                out_load = 1'b0;
                                state_next = S_DONE;
                                phase_next = 1'b1;
                            end
                            else
                            begin
                                cmd.op = OP_DIV_INIT;
                                cmd.dsrc = DSRC_NEG;
                                phase_next = 1'b0;
                                state_next = S_DIV;
                            end
                        end
                        MODE_RESEED:
                        begin
                            cmd.op = OP_RES_CLR;
                            slot_next = 2'd0;
                            state_next = S_MIXA;
                        end
                        MODE_JUMP, MODE_LONGJUMP:
                        begin
                            cmd.op = OP_JACC_CLR;
                            cnt_next = 8'd0;
                            long_next = (mode == MODE_LONGJUMP);
                            state_next = S_JUMP;
                        end
                        default:
                        begin
                            cmd.op = OP_RES_CLR;
                            state_next = S_DONE;
                            phase_next = 1'b1;
                        end
                    endcase
                end
            end
            S_MIXA:
            begin
                cmd.op = OP_MIX_ADD;
                cnt_next = 8'd0;
                state_next = S_MIXM;
            end
            S_MIXM:
            begin
                // two rounds, each an xorshift then a three-step multiply
                case (cnt_reg[1:0])
                    2'd0:    cmd.op = OP_MIX_PRE;
                    2'd1:    cmd.op = OP_MUL_LL;
                    2'd2:    cmd.op = OP_MUL_LH;
                    default: cmd.op = OP_MUL_HL;
                endcase
                cmd.mix_rnd = cnt_reg[2];
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'd7)
                    state_next = S_MIXS;
            end
            S_MIXS:
            begin
                cmd.op = OP_MIX_STORE;
                slot_next = slot_reg + 2'd1;
                if (slot_reg == 2'd3)
                begin
                    state_next = S_DONE;
                    phase_next = 1'b1;
                end
                else
                begin
                    state_next = S_MIXA;
                end
            end
            S_JUMP:
            begin
                cmd.op = OP_JUMP_STEP;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'd255)
                    state_next = S_JLOAD;
            end
            S_JLOAD:
            begin
                cmd.op = OP_JUMP_LOAD;
                state_next = S_DONE;
                phase_next = 1'b1;
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (!phase_reg)
                    begin
                        cmd.op = OP_THR_SAVE;
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        cmd.op = OP_RES_REM;
                        state_next = S_DONE;
                        phase_next = 1'b0;
                        out_load = 1'b0;
                    end
                end
                else
                begin
                    cmd.op = OP_DIV_STEP;
                end
            end
            S_DRAW:
            begin
                cmd.op = OP_ADVANCE;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.accept_val)
                begin
                    cmd.op = OP_DIV_INIT;
                    cmd.dsrc = DSRC_VALUE;
                    phase_next = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DRAW;
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (!out_busy)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // a result is shown only from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> state_reg == S_DONE)
        else $error("result loaded outside finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_JUMP && cnt_reg == 8'd255) |=> state_reg == S_JLOAD)
        else $error("jump did not finish after 256 steps");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_busy)
        else $error("result loaded into a full output register");

endmodule
`default_nettype wire

// ----- rtl/xoshiro256ss_generator_top.sv -----
// xoshiro256** generator: one 64-bit result beat per request beat.
// Input channel s_axis: tuser = mode (0 draw, 1 bounded draw, 2 reseed,
//   3 jump, 4 long jump, 5..7 unused, result 0);
//   tdata = seed_word [63:0], bound_word [127:64].
// Output channel m_axis: tdata = random_value; 0 for reseed and jumps.
// Work from the accepting edge until m_axis_tvalid rises:
//   draw, zero bound and unused modes go straight to the finish state;
//   reseed builds four splitmix64 words, each an add, two xorshift-multiply
//   rounds on one shared 32x32 multiplier, and a store into its slot;
//   jump / long jump run 256 table steps, a state load and the finish;
//   bounded draw runs a restoring remainder pass for the threshold, draws
//   until one is accepted, then a second pass on the accepted draw.
// One request is worked at a time; s_axis_tready rises as the result is
// loaded, so a new draw is taken only once the last result is loaded.
// The output register parts the two sides: a new request is taken while a
// result waits; if the receiver stalls, the next result holds in the
// finish state and s_axis_tready stays low until the register drains.
// Reset loads the state that seeding with zero gives; no clearing pass.
`default_nettype none
module xoshiro256ss_generator_top
    import xo256_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [2:0]   s_axis_tuser,  // mode
    input  wire logic [127:0] s_axis_tdata,  // seed_word, bound_word
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata   // random_value
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [63:0] dp_result;
    logic        out_load;
    logic        out_busy;
    logic        valid_reg;
    logic [63:0] data_reg;

    // output register full and not draining this cycle
    assign out_busy = valid_reg && !m_axis_tready;

    xo256_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .mode     (s_axis_tuser),
        .out_busy (out_busy),
        .out_load (out_load),
        .cmd      (cmd),
        .stat     (stat)
    );

    xo256_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .seed_word  (s_axis_tdata[63:0]),
        .bound_word (s_axis_tdata[127:64]),
        .stat       (stat),
        .result     (dp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                valid_reg <= 1'b1;
            else if (m_axis_tready)
                valid_reg <= 1'b0;
        end
    end

    // datapath result: draw value, remainder, or zero
    always_ff @(posedge clk)
    begin
        if (out_load)
            data_reg <= dp_result;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule
`default_nettype wire
